// ===== rtl/core/svs_pkg.sv =====
// Shared types and constants for the supply voltage supervisor.
package svs_pkg;

  localparam int unsigned MvW  = 16;
  localparam int unsigned CntW = 16;
  localparam int unsigned IdxW = 3;
  localparam int unsigned StW  = 3;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegLowThr     = 3'd0;
  localparam logic [IdxW-1:0] RegHighThr    = 3'd1;
  localparam logic [IdxW-1:0] RegHyst       = 3'd2;
  localparam logic [IdxW-1:0] RegCutoffThr  = 3'd3;
  localparam logic [IdxW-1:0] RegConfirm    = 3'd4;
  localparam logic [IdxW-1:0] RegCutConfirm = 3'd5;
  localparam logic [IdxW-1:0] RegCutEnable  = 3'd6;

  // Reset values
  localparam logic [MvW-1:0]  RstLowThr     = 16'd7550;
  localparam logic [MvW-1:0]  RstHighThr    = 16'd31300;
  localparam logic [MvW-1:0]  RstHyst       = 16'd500;
  localparam logic [MvW-1:0]  RstCutoffThr  = 16'd3500;
  localparam logic [CntW-1:0] RstConfirm    = 16'd400;
  localparam logic [CntW-1:0] RstCutConfirm = 16'd100;

  typedef struct packed {
    logic [MvW-1:0]  low_thr;
    logic [MvW-1:0]  high_thr;
    logic [MvW-1:0]  hyst;
    logic [MvW-1:0]  cutoff_thr;
    logic [CntW-1:0] confirm;
    logic [CntW-1:0] cut_confirm;
    logic            cut_enable;
  } cfg_t;

  typedef struct packed {
    logic [StW-1:0] state_code;
    logic           under_fault;
    logic           over_fault;
    logic           cutoff_fault;
  } result_t;

endpackage

// ===== rtl/core/svs_cfg.sv =====
// Configuration register bank for the supply voltage supervisor.
module svs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [svs_pkg::IdxW-1:0]     idx_i,
  input  logic [svs_pkg::MvW-1:0]      wdata_i,
  output svs_pkg::cfg_t                cfg_o
);

  svs_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr     <= svs_pkg::RstLowThr;
      cfg_q.high_thr    <= svs_pkg::RstHighThr;
      cfg_q.hyst        <= svs_pkg::RstHyst;
      cfg_q.cutoff_thr  <= svs_pkg::RstCutoffThr;
      cfg_q.confirm     <= svs_pkg::RstConfirm;
      cfg_q.cut_confirm <= svs_pkg::RstCutConfirm;
      cfg_q.cut_enable  <= 1'b1;
    end else if (we_i) begin
      case (idx_i)
        svs_pkg::RegLowThr:     cfg_q.low_thr     <= wdata_i;
        svs_pkg::RegHighThr:    cfg_q.high_thr    <= wdata_i;
        svs_pkg::RegHyst:       cfg_q.hyst        <= wdata_i;
        svs_pkg::RegCutoffThr:  cfg_q.cutoff_thr  <= wdata_i;
        svs_pkg::RegConfirm:    cfg_q.confirm     <= wdata_i;
        svs_pkg::RegCutConfirm: cfg_q.cut_confirm <= wdata_i;
        svs_pkg::RegCutEnable:  cfg_q.cut_enable  <= wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/svs_engine.sv =====
// Supervisor state machine: window compares, confirm counter and next state.
module svs_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [svs_pkg::MvW-1:0]  sample_i,
  input  svs_pkg::cfg_t            cfg_i,
  output svs_pkg::result_t         res_o
);

  typedef enum logic [svs_pkg::StW-1:0] {
    StNominal  = 3'd0,
    StToLow    = 3'd1,
    StLow      = 3'd2,
    StToHigh   = 3'd3,
    StHigh     = 3'd4,
    StToCutoff = 3'd5,
    StCutoff   = 3'd6
  } state_e;

  localparam int unsigned SW = svs_pkg::MvW + 2;

  state_e                     state_q, state_d;
  logic [svs_pkg::CntW-1:0]   cnt_q, cnt_d, cnt_inc;
  logic signed [SW-1:0]       s, h, lo_dn, lo_up, hi_dn, hi_up, co_dn, co_up;
  logic                       reach_cfm, reach_cut;
  logic                       under, over, cut;

  // Edges widened by two bits so they neither wrap nor go unsigned.
  always_comb begin
    s     = $signed({2'b00, sample_i});
    h     = $signed({2'b00, cfg_i.hyst});
    lo_dn = $signed({2'b00, cfg_i.low_thr}) - h;
    lo_up = $signed({2'b00, cfg_i.low_thr}) + h;
    hi_dn = $signed({2'b00, cfg_i.high_thr}) - h;
    hi_up = $signed({2'b00, cfg_i.high_thr}) + h;
    co_dn = $signed({2'b00, cfg_i.cutoff_thr}) - h;
    co_up = $signed({2'b00, cfg_i.cutoff_thr}) + h;
  end

  // Saturating run count.
  assign cnt_inc   = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign reach_cfm = (cnt_inc >= cfg_i.confirm);
  assign reach_cut = (cnt_inc >= cfg_i.cut_confirm);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    under   = 1'b0;
    over    = 1'b0;
    cut     = 1'b0;
    case (state_q)
      StNominal: begin
        if (s <= lo_dn) begin
          state_d = StToLow;
          cnt_d   = '0;
        end else if (s >= hi_up) begin
          state_d = StToHigh;
          cnt_d   = '0;
        end
      end
      StToLow: begin
        if (s > lo_dn) begin
          state_d = StNominal;
          cnt_d   = '0;
        end else if (reach_cfm) begin
          state_d = StLow;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      StLow: begin
        under = 1'b1;
        if (s >= lo_up) begin
          if (reach_cfm) begin
            state_d = StNominal;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          if (cfg_i.cut_enable && (s <= co_dn)) begin
            state_d = StToCutoff;
          end
          cnt_d = '0;
        end
      end
      StToHigh: begin
        if (s < hi_up) begin
          state_d = StNominal;
          cnt_d   = '0;
        end else if (reach_cfm) begin
          state_d = StHigh;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      StHigh: begin
        over = 1'b1;
        if (s <= hi_dn) begin
          if (reach_cfm) begin
            state_d = StNominal;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          cnt_d = '0;
        end
      end
      StToCutoff: begin
        under = 1'b1;
        if (s > co_dn) begin
          state_d = StLow;
          cnt_d   = '0;
        end else if (reach_cut) begin
          state_d = StCutoff;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      StCutoff: begin
        under = 1'b1;
        cut   = 1'b1;
        if (s >= co_up) begin
          if (reach_cfm) begin
            state_d = StLow;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end else begin
          cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StNominal;
      cnt_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_o.state_code   = state_d;
  assign res_o.under_fault  = under;
  assign res_o.over_fault   = over;
  assign res_o.cutoff_fault = cut;

  // Every entry into nominal clears the run count.
  a_nominal_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNominal) |-> (cnt_q == '0))
    else $error("confirm counter nonzero in nominal");

  // Nominal only leaves through a pending state.
  a_nominal_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && state_q == StNominal) |=>
      (state_q == StNominal || state_q == StToLow || state_q == StToHigh))
    else $error("nominal skipped a pending state");

  // Cutoff is entered only from its pending state.
  a_cutoff_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StCutoff) |-> ($past(state_q) == StToCutoff))
    else $error("cutoff entered without confirmation");

  // Unused state code never reached.
  a_no_unused_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != 3'd7)
    else $error("unused state code held");

endmodule

// ===== rtl/core/supply_voltage_supervisor_top.sv =====
// Top level of the supply voltage supervisor: handshakes, sample and result registers.
//
// Usage:
//   Input channel: in_valid_i / in_ready_o with one millivolt sample on sample_mv_i.
//   Output channel: out_valid_o / out_ready_i with the new state code and the
//   under, over and cutoff fault flags, which reflect the state held before the
//   sample was applied.
//   Configuration: write cfg_wdata_i into register cfg_idx_i while cfg_we_i is high;
//   indexes 0..6 are low, high, hysteresis, cutoff thresholds, confirm count,
//   cutoff confirm count and cutoff enable. Other indexes are dropped. Write only
//   while no sample is in flight.
//   Timing: a transferred sample is first held in the sample register, then evaluated
//   against the supervisor state, and its result is loaded into the result register
//   and shown on the output from there.
//   Throughput: one sample per cycle while out_ready_i does not stall the result;
//   the state update is a single compare/count pass between the sample and result registers.
//   Reset: rst_ni clears both pipeline valids, returns the supervisor to nominal
//   with a zero run count and loads the default thresholds.
//   Stall: while the result waits, one more sample is held in the sample register;
//   in_ready_o drops only when both registers are full and out_ready_i is low.
module supply_voltage_supervisor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svs_pkg::IdxW-1:0]      cfg_idx_i,
  input  logic [svs_pkg::MvW-1:0]       cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [svs_pkg::MvW-1:0]       sample_mv_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [svs_pkg::StW-1:0]       state_code_o,
  output logic                          under_fault_o,
  output logic                          over_fault_o,
  output logic                          cutoff_fault_o
);

  svs_pkg::cfg_t            cfg;
  svs_pkg::result_t         res;
  svs_pkg::result_t         res_q;
  logic                     in_valid_q;
  logic [svs_pkg::MvW-1:0]  sample_q;
  logic                     out_valid_q;
  logic                     advance;

  // Move the held sample forward when the result slot is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  svs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  svs_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Sample register: valid is control, payload loads on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_mv_i;
    end
  end

  // Result register: hold until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign state_code_o   = res_q.state_code;
  assign under_fault_o  = res_q.under_fault;
  assign over_fault_o   = res_q.over_fault;
  assign cutoff_fault_o = res_q.cutoff_fault;

  // Both registers full and the receiver stalled: no new sample may enter.
  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pipeline full");

  // A step always leaves a result behind.
  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("step produced no result");

  // A stalled result is not overwritten.
  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed");

endmodule
